// ===== sv/pal_pkg.sv =====
// Package for the positional array list: transaction structs, command codes,
// cell control codes and fixed field widths. No dependencies.
package pal_pkg;

   localparam int POS_W  = 7;
   localparam int ITEM_W = 32;
   localparam int LEN_W  = 7;
   localparam int SLOT_W = 10;

   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_GET    = 2'd3;

   localparam logic [1:0] OP_HOLD   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   typedef struct packed {
      logic [1:0]        command;
      logic [POS_W-1:0]  position;
      logic [ITEM_W-1:0] item_in;
   } pal_req_type;

   typedef struct packed {
      logic              ok;
      logic [ITEM_W-1:0] item_out;
      logic [LEN_W-1:0]  length;
      logic              empty_res;
   } pal_rsp_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [SLOT_W-1:0] slot;
   } pal_ctrl_type;

endpackage

// ===== sv/positional_array_list.sv =====
// Top level of the positional array list: command decode, entry count, chain
// of pal_cell entries and a two-stage registered read tree. Depends on pal_pkg and pal_cell.
//
//   channel | ports                    | handshake
//   --------+--------------------------+--------------------------------------
//   request | start, busy, req_payload | taken on start high and busy low
//   result  | rsp_strobe, rsp_payload  | one cycle per result, no backpressure
//
// One command per cycle; busy stays low. The chain of cells updates at the
// accepting edge, so the next command sees the new list at once.
// The result passes through the registered read tree after acceptance: first
// the cell groups of eight are registered, then the group merge.
// Reset clears the entry count and the result valid flags; entries are not cleared.
module positional_array_list #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  pal_pkg::pal_req_type req_payload,
   output logic                 rsp_strobe,
   output pal_pkg::pal_rsp_type rsp_payload
);
   import pal_pkg::*;

   localparam int COUNT_W    = $clog2(CAPACITY + 1);
   localparam int WIDE_W     = ((COUNT_W > POS_W) ? COUNT_W : POS_W) + 1;
   localparam int GROUP_SIZE = 8;
   localparam int GROUPS     = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   logic                  accept;
   logic [COUNT_W-1:0]    cnt_ff;
   logic [COUNT_W-1:0]    cnt_in;
   logic [WIDE_W-1:0]     pos_w;
   logic [WIDE_W-1:0]     cnt_w;
   logic                  full;
   logic                  rd_pos_ok;
   logic                  ins_pos_ok;
   logic                  cmd_ok;
   logic [1:0]            cmd_op;
   logic [SLOT_W-1:0]     cmd_slot;
   pal_ctrl_type          ctrl;
   logic [DATA_WIDTH-1:0] item_w;

   logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
   logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];
   logic [DATA_WIDTH-1:0] left_bus  [CAPACITY];
   logic [DATA_WIDTH-1:0] right_bus [CAPACITY];

   logic                  s1_valid_ff;
   logic                  s1_ok_ff;
   logic [LEN_W-1:0]      s1_len_ff;
   logic                  s1_empty_ff;
   logic [DATA_WIDTH-1:0] part_ff [GROUPS];
   logic [DATA_WIDTH-1:0] part_in [GROUPS];
   logic [DATA_WIDTH-1:0] merged;
   logic                  rsp_strobe_ff;
   pal_rsp_type           rsp_ff;
   pal_rsp_type           rsp_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign item_w = DATA_WIDTH'(req_payload.item_in);

   assign pos_w      = WIDE_W'(req_payload.position);
   assign cnt_w      = WIDE_W'(cnt_ff);
   assign full       = (cnt_ff == COUNT_W'(CAPACITY));
   assign rd_pos_ok  = (pos_w != '0) && (pos_w <= cnt_w);
   assign ins_pos_ok = (pos_w != '0) && (pos_w <= cnt_w + WIDE_W'(1));

   always_comb begin
      cmd_ok   = 1'b0;
      cmd_op   = OP_HOLD;
      cmd_slot = SLOT_W'(pos_w - WIDE_W'(1));
      unique case (req_payload.command)
         CMD_APPEND: begin
            cmd_ok   = !full;
            cmd_op   = OP_INSERT;
            cmd_slot = SLOT_W'(cnt_ff);
         end
         CMD_INSERT: begin
            cmd_ok = !full && ins_pos_ok;
            cmd_op = OP_INSERT;
         end
         CMD_REMOVE: begin
            cmd_ok = rd_pos_ok;
            cmd_op = OP_REMOVE;
         end
         CMD_GET: begin
            cmd_ok = rd_pos_ok;
            cmd_op = OP_READ;
         end
         default: begin
            cmd_ok = 1'b0;
         end
      endcase
   end

   assign ctrl.op   = (accept && cmd_ok) ? cmd_op : OP_HOLD;
   assign ctrl.slot = cmd_slot;

   always_comb begin
      cnt_in = cnt_ff;
      unique case (ctrl.op)
         OP_INSERT: cnt_in = cnt_ff + COUNT_W'(1);
         OP_REMOVE: cnt_in = cnt_ff - COUNT_W'(1);
         default:   cnt_in = cnt_ff;
      endcase
   end

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      if (k == 0) begin : g_left_edge
         assign left_bus[k] = '0;
      end else begin : g_left
         assign left_bus[k] = cell_data[k-1];
      end
      if (k == CAPACITY - 1) begin : g_right_edge
         assign right_bus[k] = '0;
      end else begin : g_right
         assign right_bus[k] = cell_data[k+1];
      end

      pal_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .COUNT_W    (COUNT_W),
         .INDEX      (k)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (cnt_ff),
         .item       (item_w),
         .left_data  (left_bus[k]),
         .right_data (right_bus[k]),
         .data_out   (cell_data[k]),
         .rd_out     (cell_rd[k])
      );
   end

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         part_in[g] = '0;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            if (g * GROUP_SIZE + j < CAPACITY) begin
               part_in[g] = part_in[g] | cell_rd[g * GROUP_SIZE + j];
            end
         end
      end
   end

   always_comb begin
      merged = '0;
      for (int g = 0; g < GROUPS; g++) begin
         merged = merged | part_ff[g];
      end
   end

   always_comb begin
      rsp_in.ok        = s1_ok_ff;
      rsp_in.item_out  = ITEM_W'(merged);
      rsp_in.length    = s1_len_ff;
      rsp_in.empty_res = s1_empty_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         s1_valid_ff   <= accept;
         rsp_strobe_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ok_ff    <= cmd_ok;
      s1_len_ff   <= LEN_W'(cnt_in);
      s1_empty_ff <= (cnt_in == '0);
      part_ff     <= part_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= COUNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_fail_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && !cmd_ok) |=> $stable(cnt_ff))
      else $error("rejected transaction changed the entry count");

   a_pipe_flow: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> rsp_strobe)
      else $error("accepted transaction lost in result pipeline");

   a_empty_match: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_payload.empty_res == (rsp_payload.length == '0)))
      else $error("empty flag disagrees with length");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_payload.ok) |-> (rsp_payload.item_out == '0))
      else $error("rejected transaction returned data");
`endif

endmodule

// ===== sv/pal_cell.sv =====
// One list entry of the cell chain: loads a new item, takes its left or right
// neighbor's entry, or holds. Depends on pal_pkg.
module pal_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int COUNT_W    = 7,
   parameter int INDEX      = 0
) (
   input  logic                   clock,
   input  pal_pkg::pal_ctrl_type  ctrl,
   input  logic [COUNT_W-1:0]     count,
   input  logic [DATA_WIDTH-1:0]  item,
   input  logic [DATA_WIDTH-1:0]  left_data,
   input  logic [DATA_WIDTH-1:0]  right_data,
   output logic [DATA_WIDTH-1:0]  data_out,
   output logic [DATA_WIDTH-1:0]  rd_out
);
   import pal_pkg::*;

   localparam int CMP_W = ((COUNT_W > SLOT_W) ? COUNT_W : SLOT_W) + 1;

   logic [CMP_W-1:0]      self_idx;
   logic [CMP_W-1:0]      next_idx;
   logic [CMP_W-1:0]      slot_idx;
   logic [CMP_W-1:0]      cnt_idx;
   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   assign self_idx = CMP_W'(INDEX);
   assign next_idx = CMP_W'(INDEX + 1);
   assign slot_idx = CMP_W'(ctrl.slot);
   assign cnt_idx  = CMP_W'(count);

   always_comb begin
      data_in = data_ff;
      unique case (ctrl.op)
         OP_INSERT: begin
            if (self_idx == slot_idx) begin
               data_in = item;
            end else if ((self_idx > slot_idx) && (self_idx <= cnt_idx)) begin
               data_in = left_data;
            end
         end
         OP_REMOVE: begin
            if ((self_idx >= slot_idx) && (next_idx < cnt_idx)) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign rd_out   = ((ctrl.op == OP_READ) && (self_idx == slot_idx)) ? data_ff : '0;

endmodule
